// ----- src/cbls_pkg.sv -----
// shared codes, constants and control/status bundles of the cbor item length scanner
package cbls_pkg;

	localparam logic [1:0] STAT_OK   = 2'd0;
	localparam logic [1:0] STAT_BAD  = 2'd1;
	localparam logic [1:0] STAT_DEEP = 2'd2;

	localparam logic [2:0] MT_BSTR  = 3'd2;
	localparam logic [2:0] MT_TSTR  = 3'd3;
	localparam logic [2:0] MT_ARRAY = 3'd4;
	localparam logic [2:0] MT_MAP   = 3'd5;
	localparam logic [2:0] MT_TAG   = 3'd6;

	localparam logic [4:0] AI_DIRECT_MAX = 5'd23;
	localparam logic [4:0] AI_ARG8       = 5'd27;

	localparam logic [5:0] LIMIT_RESET = 6'd32;

	typedef struct packed {
		logic accept;
		logic pop_wr;
		logic ph_head;
		logic ph_arg;
		logic ph_payload;
	} dp_cmd_t;

	typedef struct packed {
		logic result;
		logic go_arg;
		logic go_payload;
		logic go_pop;
	} dp_stat_t;

endpackage

// ----- src/cbls_ctrl.sv -----
// scan controller: phase sequencing, stack write-back step and handshakes
module cbls_ctrl import cbls_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     byte_valid,
	input  logic     buffer_end,
	output logic     byte_stall,
	output logic     result_valid,
	input  logic     result_stall,
	input  dp_stat_t stat,
	output dp_cmd_t  cmd
);

	typedef enum logic [4:0] {
		ST_HEAD    = 5'b00001,
		ST_ARG     = 5'b00010,
		ST_PAYLOAD = 5'b00100,
		ST_DONE    = 5'b01000,
		ST_POP     = 5'b10000
	} ctrl_state_t;

	ctrl_state_t state_q, state_d;
	logic        valid_q;
	logic        accept;

	assign byte_stall   = (state_q == ST_POP) | (valid_q & result_stall & stat.result);
	assign accept       = byte_valid & ~byte_stall;
	assign result_valid = valid_q;

	assign cmd.accept     = accept;
	assign cmd.pop_wr     = (state_q == ST_POP);
	assign cmd.ph_head    = (state_q == ST_HEAD);
	assign cmd.ph_arg     = (state_q == ST_ARG);
	assign cmd.ph_payload = (state_q == ST_PAYLOAD);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_POP: begin
				state_d = ST_HEAD;
			end
			ST_HEAD, ST_ARG, ST_PAYLOAD, ST_DONE: begin
				if (accept) begin
					if (buffer_end)
						state_d = ST_HEAD;
					else if (state_q == ST_DONE || stat.result)
						state_d = ST_DONE;
					else if (stat.go_pop)
						state_d = ST_POP;
					else if (stat.go_arg)
						state_d = ST_ARG;
					else if (stat.go_payload)
						state_d = ST_PAYLOAD;
					else
						state_d = ST_HEAD;
				end
			end
			default: begin
				state_d = ST_HEAD;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_HEAD;
			valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept && stat.result)
				valid_q <= 1'b1;
			else if (!result_stall)
				valid_q <= 1'b0;
		end
	end

	a_pop_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_POP) |=> (state_q == ST_HEAD))
		else $error("stack write-back step did not return to head decoding");

	a_end_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && buffer_end) |=> (state_q == ST_HEAD))
		else $error("buffer end did not restart the scan");

	a_result_shown: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && stat.result) |=> result_valid)
		else $error("result lost after its byte transfer");

endmodule

// ----- src/cbls_dp.sv -----
// scan datapath: head decode, argument and payload counters, child-count stack, result register
module cbls_dp import cbls_pkg::*; #(
	parameter int MAX_LEVELS,
	parameter int SIZE_BITS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  dp_cmd_t     cmd,
	output dp_stat_t    stat,
	input  logic [7:0]  data_byte,
	input  logic        buffer_end,
	input  logic        cfg_we,
	input  logic [5:0]  cfg_wdata,
	output logic [1:0]  status,
	output logic [31:0] item_size
);

	localparam int LW = $clog2(MAX_LEVELS + 1);
	localparam int IW = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
	localparam logic [5:0] LIMIT_CAP = 6'(MAX_LEVELS);

	logic [5:0]           limit_q;
	logic [LW-1:0]        level_q;
	logic [SIZE_BITS-1:0] count_q;
	logic [2:0]           major_q;
	logic [63:0]          arg_q;
	logic [3:0]           left_q;
	logic [SIZE_BITS-1:0] pay_q;
	logic [MAX_LEVELS-1:0] last_child_q;
	logic [IW-1:0]        pop_idx_q;
	logic [63:0]          rd_q;
	logic [1:0]           status_q;
	logic [31:0]          size_q;
	logic [63:0]          stack [MAX_LEVELS];

	logic [4:0]           ai;
	logic [2:0]           maj;
	logic [63:0]          val;
	logic [63:0]          arg_new;
	logic [3:0]           left_new;
	logic [SIZE_BITS-1:0] pay_new;
	logic [SIZE_BITS-1:0] count_inc;
	logic                 count_full;
	logic [5:0]           lim;
	logic [63:0]          kids;
	logic                 hd_go, container, close, push, res;
	logic [1:0]           code;
	logic                 go_arg, go_pay, go_pop;
	logic                 found;
	logic [IW-1:0]        find_idx;
	logic                 scanning;

	assign ai         = data_byte[4:0];
	assign maj        = cmd.ph_head ? data_byte[7:5] : major_q;
	assign arg_new    = {arg_q[55:0], data_byte};
	assign left_new   = left_q - 4'd1;
	assign pay_new    = pay_q - SIZE_BITS'(1);
	assign count_inc  = count_q + SIZE_BITS'(1);
	assign count_full = &count_q;
	assign lim        = (limit_q > LIMIT_CAP) ? LIMIT_CAP : limit_q;
	assign scanning   = cmd.ph_head | cmd.ph_arg | cmd.ph_payload;

	// innermost open level that still has children left after this one
	always_comb begin
		found    = 1'b0;
		find_idx = '0;
		for (int i = 0; i < MAX_LEVELS; i++) begin
			if (!last_child_q[i] && (LW'(i) < level_q)) begin
				found    = 1'b1;
				find_idx = IW'(i);
			end
		end
	end

	always_comb begin
		res       = 1'b0;
		code      = STAT_OK;
		go_arg    = 1'b0;
		go_pay    = 1'b0;
		go_pop    = 1'b0;
		hd_go     = 1'b0;
		container = 1'b0;
		close     = 1'b0;
		push      = 1'b0;
		val       = '0;
		kids      = '0;
		if (scanning) begin
			if (count_full) begin
				res  = 1'b1;
				code = STAT_BAD;
			end else if (cmd.ph_head) begin
				if (ai <= AI_DIRECT_MAX) begin
					hd_go = 1'b1;
					val   = 64'(ai);
				end else if (ai <= AI_ARG8) begin
					go_arg = 1'b1;
				end else begin
					res  = 1'b1;
					code = STAT_BAD;
				end
			end else if (cmd.ph_arg) begin
				if (left_new == 4'd0) begin
					hd_go = 1'b1;
					val   = arg_new;
				end else begin
					go_arg = 1'b1;
				end
			end else begin
				if (pay_new == '0)
					close = 1'b1;
				else
					go_pay = 1'b1;
			end
			if (hd_go) begin
				case (maj)
					MT_BSTR, MT_TSTR: begin
						if (val == 64'd0) begin
							close = 1'b1;
						end else if (val > 64'(~count_inc)) begin
							res  = 1'b1;
							code = STAT_BAD;
						end else begin
							go_pay = 1'b1;
						end
					end
					MT_ARRAY: begin
						container = 1'b1;
						kids      = val;
					end
					MT_MAP: begin
						if (val[63]) begin
							res  = 1'b1;
							code = STAT_BAD;
						end else begin
							container = 1'b1;
							kids      = {val[62:0], 1'b0};
						end
					end
					MT_TAG: begin
						container = 1'b1;
						kids      = 64'd1;
					end
					default: begin
						close = 1'b1;
					end
				endcase
				if (container) begin
					if (kids == 64'd0) begin
						close = 1'b1;
					end else if (6'(level_q) >= lim) begin
						res  = 1'b1;
						code = (maj == MT_TAG || !buffer_end) ? STAT_DEEP : STAT_BAD;
					end else begin
						push = 1'b1;
					end
				end
			end
			if (close) begin
				if (found)
					go_pop = 1'b1;
				else
					res = 1'b1;
			end
			if (!res && buffer_end) begin
				res  = 1'b1;
				code = STAT_BAD;
			end
			if (res)
				go_pop = 1'b0;
		end
	end

	assign stat.result     = res;
	assign stat.go_arg     = go_arg;
	assign stat.go_payload = go_pay;
	assign stat.go_pop     = go_pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RESET;
			level_q <= '0;
			count_q <= '0;
		end else begin
			if (cfg_we)
				limit_q <= cfg_wdata;
			if (cmd.accept) begin
				if (buffer_end) begin
					level_q <= '0;
					count_q <= '0;
				end else begin
					if (scanning && !count_full)
						count_q <= count_inc;
					if (push)
						level_q <= level_q + LW'(1);
					else if (go_pop)
						level_q <= LW'(find_idx) + LW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			if (cmd.ph_head)
				major_q <= data_byte[7:5];
			if (cmd.ph_head && go_arg) begin
				arg_q  <= '0;
				left_q <= 4'd1 << ai[1:0];
			end else if (cmd.ph_arg) begin
				arg_q  <= arg_new;
				left_q <= left_new;
			end
			if (cmd.ph_payload)
				pay_q <= pay_new;
			else if (go_pay)
				pay_q <= SIZE_BITS'(val);
			if (res) begin
				status_q <= code;
				size_q   <= (code == STAT_OK) ? 32'(count_inc) : 32'd0;
			end
		end
	end

	// child-count stack with its last-child flags
	always_ff @(posedge clk) begin
		if (cmd.pop_wr) begin
			stack[pop_idx_q]        <= rd_q - 64'd1;
			last_child_q[pop_idx_q] <= (rd_q == 64'd2);
		end else if (cmd.accept && push) begin
			stack[IW'(level_q)]        <= kids;
			last_child_q[IW'(level_q)] <= (kids == 64'd1);
		end
		if (cmd.accept && go_pop) begin
			rd_q      <= stack[find_idx];
			pop_idx_q <= find_idx;
		end
	end

	assign status    = status_q;
	assign item_size = size_q;

	a_level_bound: assert property (@(posedge clk) disable iff (!arst_n)
		level_q <= LW'(MAX_LEVELS))
		else $error("nesting level beyond stack depth");

	a_pop_is_top: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pop_wr |-> (level_q == LW'(pop_idx_q) + LW'(1)))
		else $error("stack write-back not at the innermost open level");

	a_one_action: assert property (@(posedge clk) disable iff (!arst_n)
		!(go_pop && (res || push)))
		else $error("stack pop decided together with a push or a result");

endmodule

// ----- src/cbor_item_length_scanner.sv -----
// top level of the cbor item length scanner
// one byte per cycle while byte_stall is low; a byte that completes an item inside an open container
// is followed by a stack write-back step (stack memory read, then decremented count written back)
// the result is registered and shows in the cycle after the transfer of the byte that decides it
// arst_n clears the scan state and sets the nesting limit (limit_q) to 32; the stack memory is not cleared
module cbor_item_length_scanner import cbls_pkg::*; #(
	parameter int MAX_LEVELS = 32,
	parameter int SIZE_BITS  = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        byte_valid,
	output logic        byte_stall,
	input  logic [7:0]  data_byte,
	input  logic        buffer_end,
	output logic        result_valid,
	input  logic        result_stall,
	output logic [1:0]  status,
	output logic [31:0] item_size,
	input  logic        cfg_we,
	input  logic [5:0]  cfg_wdata
);

	dp_cmd_t  cmd;
	dp_stat_t stat;

	cbls_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.byte_valid   (byte_valid),
		.buffer_end   (buffer_end),
		.byte_stall   (byte_stall),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.stat         (stat),
		.cmd          (cmd)
	);

	cbls_dp #(
		.MAX_LEVELS (MAX_LEVELS),
		.SIZE_BITS  (SIZE_BITS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.data_byte  (data_byte),
		.buffer_end (buffer_end),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.status     (status),
		.item_size  (item_size)
	);

endmodule
